>>> hw/rtl/mm_symbol_timing_recovery_core_defines.svh
// Assertion helpers for the symbol timing recovery core.
`ifndef MM_SYMBOL_TIMING_RECOVERY_CORE_DEFINES_SVH
`define MM_SYMBOL_TIMING_RECOVERY_CORE_DEFINES_SVH

// Checked only while out of reset.
`define MMTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MMTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mmtr_pkg.sv
package mmtr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int ERR_W       = SAMPLE_BITS + 1;
  localparam int STEP_W      = 24;
  localparam int GAIN_W      = 24;
  localparam int POS_W       = 26;
  localparam int GAIN_SHIFT  = 16;
  localparam int PROD_W      = GAIN_W + ERR_W;
  localparam int SUM_W       = PROD_W + 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int ONE_SAMPLE  = 65536;
  localparam int HALF_SAMPLE = 32768;

  localparam logic signed [POS_W-1:0] POS_ONE   = POS_W'(ONE_SAMPLE);
  localparam logic signed [POS_W-1:0] POS_HALF  = POS_W'(HALF_SAMPLE);
  localparam logic signed [POS_W-1:0] POS_FLOOR = POS_W'(-HALF_SAMPLE);
  localparam logic signed [SUM_W-1:0] SUM_ONE   = SUM_W'(ONE_SAMPLE);

  localparam logic [STEP_W-1:0]        RST_INITIAL_STEP = STEP_W'(327680);
  localparam logic [STEP_W-1:0]        RST_STEP_MAX     = STEP_W'(393216);
  localparam logic [STEP_W-1:0]        RST_STEP_MIN     = STEP_W'(262144);
  localparam logic signed [GAIN_W-1:0] RST_LOOP_GAIN    = GAIN_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_STEP = 8'd0,
    CFG_STEP_MAX     = 8'd1,
    CFG_STEP_MIN     = 8'd2,
    CFG_LOOP_GAIN    = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                     pick;
    logic signed [ERR_W-1:0]  timing_error;
    logic [STEP_W-1:0]        step_nxt;
    logic signed [POS_W-1:0]  pos_nxt;
  } calc_res_t;

endpackage

>>> hw/rtl/mmtr_if.sv
interface mmtr_samp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] sample;
  logic [mmtr_pkg::TIME_W-1:0]            sample_time;

  modport source (output valid, output sample, output sample_time, input ready);
  modport sink   (input valid, input sample, input sample_time, output ready);
endinterface

interface mmtr_sym_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] symbol;
  logic [mmtr_pkg::TIME_W-1:0]            symbol_time;
  logic signed [mmtr_pkg::ERR_W-1:0]      timing_error;

  modport source (output valid, output symbol, output symbol_time, output timing_error,
                  input ready);
  modport sink   (input valid, input symbol, input symbol_time, input timing_error,
                  output ready);
endinterface

interface mmtr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mmtr_pkg::CFG_IDX_W-1:0]    index;
  logic [mmtr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/mmtr_step_calc.sv
module mmtr_step_calc (
  input  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] last_symbol_i,
  input  logic signed [mmtr_pkg::POS_W-1:0]       position_i,
  input  logic [mmtr_pkg::STEP_W-1:0]             step_i,
  input  logic [mmtr_pkg::STEP_W-1:0]             step_max_i,
  input  logic [mmtr_pkg::STEP_W-1:0]             step_min_i,
  input  logic signed [mmtr_pkg::GAIN_W-1:0]      loop_gain_i,
  output mmtr_pkg::calc_res_t                     res_o
);

  logic signed [mmtr_pkg::ERR_W:0]        cur_ext;
  logic signed [mmtr_pkg::ERR_W:0]        last_ext;
  logic signed [mmtr_pkg::ERR_W:0]        term_cur;
  logic signed [mmtr_pkg::ERR_W:0]        term_last;
  logic signed [mmtr_pkg::ERR_W:0]        err_wide;
  logic signed [mmtr_pkg::ERR_W-1:0]      err;
  logic signed [mmtr_pkg::PROD_W-1:0]     prod;
  logic signed [mmtr_pkg::SUM_W-1:0]      step_ext;
  logic signed [mmtr_pkg::SUM_W-1:0]      max_ext;
  logic signed [mmtr_pkg::SUM_W-1:0]      min_ext;
  logic signed [mmtr_pkg::SUM_W-1:0]      sum;
  logic signed [mmtr_pkg::SUM_W-1:0]      sum_hi;
  logic signed [mmtr_pkg::SUM_W-1:0]      sum_lo;
  logic signed [mmtr_pkg::SUM_W-1:0]      sum_clamped;
  logic [mmtr_pkg::STEP_W-1:0]            step_nxt;

  assign cur_ext  = (mmtr_pkg::ERR_W + 1)'(sample_i);
  assign last_ext = (mmtr_pkg::ERR_W + 1)'(last_symbol_i);

  // sign(last)*cur and sign(cur)*last as selects, no multiplier needed
  always_comb begin
    if (last_symbol_i > 0) begin
      term_cur = cur_ext;
    end else if (last_symbol_i < 0) begin
      term_cur = -cur_ext;
    end else begin
      term_cur = '0;
    end
    if (sample_i > 0) begin
      term_last = last_ext;
    end else if (sample_i < 0) begin
      term_last = -last_ext;
    end else begin
      term_last = '0;
    end
  end

  assign err_wide = term_cur - term_last;
  assign err      = err_wide[mmtr_pkg::ERR_W-1:0];

  assign prod = loop_gain_i * err;

  assign step_ext = mmtr_pkg::SUM_W'({1'b0, step_i});
  assign max_ext  = mmtr_pkg::SUM_W'({1'b0, step_max_i});
  assign min_ext  = mmtr_pkg::SUM_W'({1'b0, step_min_i});

  // arithmetic shift gives the floor of gain*err / 2^shift
  assign sum = step_ext + mmtr_pkg::SUM_W'(prod >>> mmtr_pkg::GAIN_SHIFT);

  // max first, then min, then one sample: min wins when limits cross
  assign sum_hi      = (sum > max_ext) ? max_ext : sum;
  assign sum_lo      = (sum_hi < min_ext) ? min_ext : sum_hi;
  assign sum_clamped = (sum_lo < mmtr_pkg::SUM_ONE) ? mmtr_pkg::SUM_ONE : sum_lo;
  assign step_nxt    = sum_clamped[mmtr_pkg::STEP_W-1:0];

  always_comb begin
    res_o.pick         = (position_i < mmtr_pkg::POS_HALF);
    res_o.timing_error = err;
    res_o.step_nxt     = step_nxt;
    if (res_o.pick) begin
      res_o.pos_nxt = position_i + mmtr_pkg::POS_W'({1'b0, step_nxt}) - mmtr_pkg::POS_ONE;
    end else begin
      res_o.pos_nxt = position_i - mmtr_pkg::POS_ONE;
    end
  end

endmodule

>>> hw/rtl/mm_symbol_timing_recovery_core.sv
// Channel   Dir   Carries                                   Modport
// samp_i    in    sample, sample_time                       mmtr_samp_if.sink
// sym_o     out   symbol, symbol_time, timing_error         mmtr_sym_if.source
// cfg_i     in    register index, write data                mmtr_cfg_if.sink
//
// One sample beat per cycle while no picking beat waits on a stalled sym_o; a picked
// symbol goes from samp_i through the input register, then the result register.
// The pick, error, gain multiply, step clamp and position update all sit in
// combinational logic between the input register and the result register.
// Reset loads register defaults, position zero, step = initial_step; no sweep.
// A stalled symbol output only holds the input stage when that beat picks;
// non-picking samples keep flowing. cfg_i is always ready.

`include "mm_symbol_timing_recovery_core_defines.svh"

module mm_symbol_timing_recovery_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  mmtr_samp_if.sink       samp_i,
  mmtr_sym_if.source      sym_o,
  mmtr_cfg_if.sink        cfg_i
);

  // configuration registers
  logic [mmtr_pkg::STEP_W-1:0]        initial_step_q;
  logic [mmtr_pkg::STEP_W-1:0]        step_max_q;
  logic [mmtr_pkg::STEP_W-1:0]        step_min_q;
  logic signed [mmtr_pkg::GAIN_W-1:0] loop_gain_q;
  logic                               cfg_wr;

  // loop state
  logic signed [mmtr_pkg::POS_W-1:0]       position_q;
  logic [mmtr_pkg::STEP_W-1:0]             step_q;
  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] last_symbol_q;

  // input stage
  logic                                    s1_valid_q;
  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] s1_sample_q;
  logic [mmtr_pkg::TIME_W-1:0]             s1_time_q;
  logic                                    s1_adv;
  logic                                    s1_pick;
  logic                                    in_beat;

  // result stage
  logic                                    sym_valid_q;
  logic signed [mmtr_pkg::SAMPLE_BITS-1:0] sym_symbol_q;
  logic [mmtr_pkg::TIME_W-1:0]             sym_time_q;
  logic signed [mmtr_pkg::ERR_W-1:0]       sym_err_q;

  mmtr_pkg::calc_res_t calc;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_step_q <= mmtr_pkg::RST_INITIAL_STEP;
      step_max_q     <= mmtr_pkg::RST_STEP_MAX;
      step_min_q     <= mmtr_pkg::RST_STEP_MIN;
      loop_gain_q    <= mmtr_pkg::RST_LOOP_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        mmtr_pkg::CFG_INITIAL_STEP: initial_step_q <= cfg_i.data[mmtr_pkg::STEP_W-1:0];
        mmtr_pkg::CFG_STEP_MAX:     step_max_q     <= cfg_i.data[mmtr_pkg::STEP_W-1:0];
        mmtr_pkg::CFG_STEP_MIN:     step_min_q     <= cfg_i.data[mmtr_pkg::STEP_W-1:0];
        mmtr_pkg::CFG_LOOP_GAIN:    loop_gain_q    <= cfg_i.data[mmtr_pkg::GAIN_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  mmtr_step_calc u_calc (
    .sample_i      (s1_sample_q),
    .last_symbol_i (last_symbol_q),
    .position_i    (position_q),
    .step_i        (step_q),
    .step_max_i    (step_max_q),
    .step_min_i    (step_min_q),
    .loop_gain_i   (loop_gain_q),
    .res_o         (calc)
  );

  // a picking beat needs room in the result register; others always move on
  assign s1_pick      = s1_valid_q && calc.pick;
  assign s1_adv       = s1_valid_q && (!calc.pick || !sym_valid_q || sym_o.ready);
  assign samp_i.ready = !s1_valid_q || s1_adv;
  assign in_beat      = samp_i.valid && samp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (samp_i.ready) begin
      s1_valid_q <= samp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_sample_q <= samp_i.sample;
      s1_time_q   <= samp_i.sample_time;
    end
  end

  // state update: an initial_step write reloads the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      step_q        <= mmtr_pkg::RST_INITIAL_STEP;
      last_symbol_q <= '0;
    end else begin
      if (cfg_wr && (cfg_i.index == mmtr_pkg::CFG_INITIAL_STEP)) begin
        step_q <= cfg_i.data[mmtr_pkg::STEP_W-1:0];
      end else if (s1_adv && calc.pick) begin
        step_q <= calc.step_nxt;
      end
      if (s1_adv) begin
        position_q <= calc.pos_nxt;
        if (calc.pick) begin
          last_symbol_q <= s1_sample_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_valid_q <= 1'b0;
    end else if (s1_adv && calc.pick) begin
      sym_valid_q <= 1'b1;
    end else if (sym_o.ready) begin
      sym_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && calc.pick) begin
      sym_symbol_q <= s1_sample_q;
      sym_time_q   <= s1_time_q;
      sym_err_q    <= calc.timing_error;
    end
  end

  assign sym_o.valid        = sym_valid_q;
  assign sym_o.symbol       = sym_symbol_q;
  assign sym_o.symbol_time  = sym_time_q;
  assign sym_o.timing_error = sym_err_q;

  // a picked beat always lands in the result register
  `MMTR_ASSERT(a_pick_to_out, clk_i, rst_ni, s1_pick && s1_adv |=> sym_valid_q,
               "picked beat not presented")
  // a stalled input stage keeps its beat
  `MMTR_ASSERT(a_s1_hold, clk_i, rst_ni,
               s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_sample_q),
               "input stage lost a stalled beat")
  // the applied step never drops below one sample, so position never falls below minus half
  `MMTR_ASSERT_ALWAYS(a_pos_floor, clk_i, position_q >= mmtr_pkg::POS_FLOOR,
                      "position below minus half sample")

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A picked symbol goes through the input register, then the result register.
  localparam int PIPE_LATENCY   = 2;
  localparam int MAX_GAP        = 5;
  // Long output stall; the watchdog limit sits well above it.
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int STALL_ITEMS    = 60;

  localparam logic [mmtr_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
    mmtr_pkg::CFG_IDX_W'(int'(mmtr_pkg::CFG_LOOP_GAIN) + 1);
  localparam int unsigned STEP_TOP = (1 << mmtr_pkg::STEP_W) - 1;
  localparam int GAIN_MAX = (1 << (mmtr_pkg::GAIN_W - 1)) - 1;
  localparam int GAIN_MIN = -(1 << (mmtr_pkg::GAIN_W - 1));
  localparam logic signed [mmtr_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
    {1'b0, {(mmtr_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [mmtr_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(mmtr_pkg::SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [mmtr_pkg::SAMPLE_BITS-1:0] symbol;
    logic [mmtr_pkg::TIME_W-1:0]             stamp;
    logic signed [mmtr_pkg::ERR_W-1:0]       err;
  } symbol_beat_t;

  logic clk;
  logic rst_n;

  mmtr_samp_if samp ();
  mmtr_sym_if  sym ();
  mmtr_cfg_if  cfg ();

  mm_symbol_timing_recovery_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .samp_i (samp),
    .sym_o  (sym),
    .cfg_i  (cfg)
  );

  // Symbols predicted but not yet seen on sym_o, oldest first.
  symbol_beat_t pending_symbols[$];

  // Register shadow and timing loop state of the predictor.
  logic [mmtr_pkg::STEP_W-1:0]        reg_initial_step;
  logic [mmtr_pkg::STEP_W-1:0]        reg_step_max;
  logic [mmtr_pkg::STEP_W-1:0]        reg_step_min;
  logic signed [mmtr_pkg::GAIN_W-1:0] reg_loop_gain;
  longint                             trk_position;  // Q.16, samples to next symbol instant
  longint                             trk_step;      // Q8.16 samples per symbol
  longint                             trk_last;      // last picked symbol

  int n_samples;
  int n_symbols;
  int n_writes;
  int n_settings;
  int n_errors;

  // Idling control shared by sender and receiver; off gives back-to-back beats.
  bit idle_on;
  int rx_wait;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint signum(longint x);
    if (x > 0) return 1;
    if (x < 0) return -1;
    return 0;
  endfunction

  // Timing loop for one sample beat: pick when position rounds to zero,
  // Mueller-Muller error, gain with floor shift, clamp, then advance.
  function automatic void track_sample(logic signed [mmtr_pkg::SAMPLE_BITS-1:0] smp,
                                       logic [mmtr_pkg::TIME_W-1:0] stamp);
    longint       cur;
    longint       err;
    longint       nstep;
    symbol_beat_t beat;
    cur = longint'(smp);
    if (trk_position < mmtr_pkg::HALF_SAMPLE) begin
      err   = signum(trk_last) * cur - signum(cur) * trk_last;
      nstep = trk_step + ((longint'(reg_loop_gain) * err) >>> mmtr_pkg::GAIN_SHIFT);
      if (nstep > longint'(reg_step_max)) nstep = longint'(reg_step_max);
      // min check after max: an inverted pair ends at the minimum
      if (nstep < longint'(reg_step_min)) nstep = longint'(reg_step_min);
      // never below one sample, so one symbol per beat at most
      if (nstep < mmtr_pkg::ONE_SAMPLE) nstep = mmtr_pkg::ONE_SAMPLE;
      trk_step     = nstep;
      trk_position = trk_position + trk_step;
      trk_last     = cur;
      beat.symbol  = smp;
      beat.stamp   = stamp;
      beat.err     = err[mmtr_pkg::ERR_W-1:0];
      pending_symbols.push_back(beat);
    end
    trk_position = trk_position - mmtr_pkg::ONE_SAMPLE;
  endfunction

  function automatic void apply_register(logic [mmtr_pkg::CFG_IDX_W-1:0] idx,
                                         logic [mmtr_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mmtr_pkg::CFG_INITIAL_STEP: begin
        reg_initial_step = data[mmtr_pkg::STEP_W-1:0];
        trk_step         = longint'(reg_initial_step);
      end
      mmtr_pkg::CFG_STEP_MAX:  reg_step_max  = data[mmtr_pkg::STEP_W-1:0];
      mmtr_pkg::CFG_STEP_MIN:  reg_step_min  = data[mmtr_pkg::STEP_W-1:0];
      mmtr_pkg::CFG_LOOP_GAIN: reg_loop_gain = data[mmtr_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Register payload with random junk above the register width.
  function automatic logic [mmtr_pkg::CFG_DATA_W-1:0] with_junk(
    logic [mmtr_pkg::STEP_W-1:0] v);
    logic [mmtr_pkg::CFG_DATA_W-1:0] word;
    word = $urandom;
    word[mmtr_pkg::STEP_W-1:0] = v;
    return word;
  endfunction

  task automatic note_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("tb: %s", msg);
  endtask

  // One sample beat; valid is left high so a zero gap gives back-to-back beats.
  task automatic send_sample(logic signed [mmtr_pkg::SAMPLE_BITS-1:0] smp,
                             logic [mmtr_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      samp.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samp.sample      = smp;
    samp.sample_time = stamp;
    samp.valid       = 1'b1;
    do @(posedge clk); while (!samp.ready);
    track_sample(smp, stamp);
    n_samples++;
    @(negedge clk);
  endtask

  // Sender stops, every predicted symbol drains, then the pipe empties of
  // non-picking beats, which leave nothing to wait for.
  task automatic wait_idle();
    samp.valid = 1'b0;
    while (pending_symbols.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_register(logic [mmtr_pkg::CFG_IDX_W-1:0] idx,
                                logic [mmtr_pkg::CFG_DATA_W-1:0] data);
    cfg.index = idx;
    cfg.data  = data;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    apply_register(idx, data);
    n_writes++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic configure(int unsigned init, int unsigned smax, int unsigned smin, int gain);
    wait_idle();
    write_register(mmtr_pkg::CFG_STEP_MAX, with_junk(smax[mmtr_pkg::STEP_W-1:0]));
    write_register(mmtr_pkg::CFG_STEP_MIN, with_junk(smin[mmtr_pkg::STEP_W-1:0]));
    write_register(mmtr_pkg::CFG_LOOP_GAIN, with_junk(gain[mmtr_pkg::GAIN_W-1:0]));
    write_register(mmtr_pkg::CFG_INITIAL_STEP, with_junk(init[mmtr_pkg::STEP_W-1:0]));
    n_settings++;
  endtask

  // Extremes of the fields and the named corner cases, about two dozen beats.
  task automatic test_directed();
    idle_on = 1'b1;
    // reset values: position zero, so the first beat is a symbol with zero error
    send_sample(SAMPLE_MAX, '0);
    send_sample(SAMPLE_MIN, '1);
    send_sample(16'sd0, 32'h8000_0000);
    send_sample(-16'sd1, 32'h7FFF_FFFF);
    send_sample(16'sd1, $urandom);
    send_sample(SAMPLE_MAX, $urandom);
    send_sample(SAMPLE_MIN, $urandom);
    send_sample(-16'sd1, $urandom);
    send_sample(16'sd1, $urandom);
    send_sample(SAMPLE_MIN, $urandom);

    // minimum above maximum: step settles on the minimum
    configure(5 * mmtr_pkg::ONE_SAMPLE, 3 * mmtr_pkg::ONE_SAMPLE, 6 * mmtr_pkg::ONE_SAMPLE, 64);
    repeat (6) send_sample(mmtr_pkg::SAMPLE_BITS'($urandom), $urandom);

    // all limits zero (junk only above bit 23): step forced up to one sample
    wait_idle();
    write_register(mmtr_pkg::CFG_STEP_MAX, 32'hFF00_0000);
    write_register(mmtr_pkg::CFG_STEP_MIN, 32'hA500_0000);
    write_register(mmtr_pkg::CFG_INITIAL_STEP, 32'h5A00_0000);
    n_settings++;
    send_sample(SAMPLE_MAX, $urandom);
    send_sample(SAMPLE_MIN, $urandom);
    send_sample(SAMPLE_MIN, $urandom);
    send_sample(SAMPLE_MAX, $urandom);

    // gain at both ends with room to move between one and two samples
    wait_idle();
    write_register(mmtr_pkg::CFG_STEP_MAX,
                   with_junk(mmtr_pkg::STEP_W'(2 * mmtr_pkg::ONE_SAMPLE)));
    write_register(mmtr_pkg::CFG_LOOP_GAIN, with_junk(GAIN_MAX[mmtr_pkg::GAIN_W-1:0]));
    send_sample(SAMPLE_MAX, $urandom);
    send_sample(-16'sd1234, $urandom);
    wait_idle();
    write_register(mmtr_pkg::CFG_LOOP_GAIN, with_junk(GAIN_MIN[mmtr_pkg::GAIN_W-1:0]));
    send_sample(SAMPLE_MIN, $urandom);
    send_sample(16'sd4321, $urandom);

    // index past the register list must leave every register alone
    wait_idle();
    write_register(CFG_FIRST_UNUSED, $urandom);
    write_register(mmtr_pkg::CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED),
                                                       (1 << mmtr_pkg::CFG_IDX_W) - 1)),
                   $urandom);
    send_sample(16'sd777, $urandom);
  endtask

  // Unit step, so every beat picks once position is below half; sym_o is held off
  // long, so the core fills and stalls samp_i; then the sender waits for the last symbol.
  task automatic test_output_stall();
    int k;
    configure(mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE, int'($urandom));
    idle_on = 1'b0;
    hold_req++;
    for (k = 0; k < STALL_ITEMS; k++) send_sample(mmtr_pkg::SAMPLE_BITS'($urandom), $urandom);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Baseband-like stream at roughly the configured symbol period, with some
  // full-range noise beats, idling stretches toggled and one drain pause.
  task automatic run_tracking(int unsigned init, int unsigned smax, int unsigned smin,
                              int gain, int n_items);
    int unsigned                             sym_period;
    int unsigned                             sym_phase;
    int                                      level;
    int                                      v;
    int                                      k;
    int                                      pause_at;
    logic [mmtr_pkg::TIME_W-1:0]             stamp;
    logic signed [mmtr_pkg::SAMPLE_BITS-1:0] smp;
    configure(init, smax, smin, gain);
    sym_period = init - init / 32 + $urandom_range(0, init / 16);
    if (sym_period < mmtr_pkg::ONE_SAMPLE) sym_period = mmtr_pkg::ONE_SAMPLE;
    sym_phase = 0;
    level     = 0;
    stamp     = $urandom;
    pause_at  = $urandom_range(n_items / 4, 3 * n_items / 4);
    for (k = 0; k < n_items; k++) begin
      if (k % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (k == pause_at) wait_idle();
      if ($urandom_range(0, 9) == 0) begin
        smp   = mmtr_pkg::SAMPLE_BITS'($urandom);
        stamp = $urandom;
      end else begin
        sym_phase += mmtr_pkg::ONE_SAMPLE;
        if (sym_phase >= sym_period) begin
          sym_phase -= sym_period;
          level = int'($urandom_range(1000, 30000));
          if ($urandom_range(0, 1) == 0) level = -level;
        end
        v = level + int'($urandom_range(0, 1000)) - 500;
        if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
        if (v < int'(SAMPLE_MIN)) v = int'(SAMPLE_MIN);
        smp   = mmtr_pkg::SAMPLE_BITS'(v);
        stamp = stamp + 1;
      end
      send_sample(smp, stamp);
    end
  endtask

  // Receiver: per-symbol random stall, or a long hold when one is requested.
  initial begin
    sym.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        sym.ready = 1'b0;
        hold_left--;
      end else if (rx_wait > 0) begin
        sym.ready = 1'b0;
        rx_wait--;
      end else begin
        sym.ready = 1'b1;
      end
    end
  end

  // Symbol checker: each accepted beat against the oldest prediction.
  always @(posedge clk) begin : check_symbols
    symbol_beat_t want;
    if (rst_n && sym.valid && sym.ready) begin
      n_symbols++;
      rx_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (pending_symbols.size() == 0) begin
        note_error($sformatf("symbol %0d not predicted: sym %0d time %h err %0d",
                             n_symbols, sym.symbol, sym.symbol_time, sym.timing_error));
      end else begin
        want = pending_symbols.pop_front();
        if (sym.symbol !== want.symbol || sym.symbol_time !== want.stamp ||
            sym.timing_error !== want.err) begin
          note_error($sformatf(
            "symbol %0d mismatch: exp sym %0d time %h err %0d, got sym %0d time %h err %0d",
            n_symbols, want.symbol, want.stamp, want.err,
            sym.symbol, sym.symbol_time, sym.timing_error));
        end
      end
    end
  end

  // Watchdog: too long with no beat on any channel means the core hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((samp.valid && samp.ready) || (sym.valid && sym.ready) || (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: no progress for %0d cycles", quiet_cycles);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    samp.valid       = 1'b0;
    samp.sample      = '0;
    samp.sample_time = '0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    rx_wait          = 0;
    hold_req         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    quiet_cycles     = 0;
    n_samples        = 0;
    n_symbols        = 0;
    n_writes         = 0;
    n_settings       = 1;
    n_errors         = 0;
    reg_initial_step = mmtr_pkg::RST_INITIAL_STEP;
    reg_step_max     = mmtr_pkg::RST_STEP_MAX;
    reg_step_min     = mmtr_pkg::RST_STEP_MIN;
    reg_loop_gain    = mmtr_pkg::RST_LOOP_GAIN;
    trk_position     = 0;
    trk_step         = longint'(mmtr_pkg::RST_INITIAL_STEP);
    trk_last         = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_output_stall();
    // near the reset limits, small gain
    run_tracking(5 * mmtr_pkg::ONE_SAMPLE, 6 * mmtr_pkg::ONE_SAMPLE, 4 * mmtr_pkg::ONE_SAMPLE,
                 64, 300);
    // unit step: every beat is a symbol once position is below half a sample
    run_tracking(mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE,
                 int'($urandom_range(0, 1 << 20)) - (1 << 19), 200);
    // random limits around a random nominal step
    repeat (2) begin
      int unsigned init;
      init = $urandom_range(mmtr_pkg::ONE_SAMPLE, 8 * mmtr_pkg::ONE_SAMPLE);
      run_tracking(init, $urandom_range(init, 10 * mmtr_pkg::ONE_SAMPLE),
                   $urandom_range(mmtr_pkg::ONE_SAMPLE, init),
                   int'($urandom_range(0, 1 << 21)) - (1 << 20), 250);
    end
    // inverted limits
    run_tracking(5 * mmtr_pkg::ONE_SAMPLE, 3 * mmtr_pkg::ONE_SAMPLE, 4 * mmtr_pkg::ONE_SAMPLE,
                 200, 200);
    // gain at both ends
    run_tracking(4 * mmtr_pkg::ONE_SAMPLE, 8 * mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE,
                 GAIN_MAX, 200);
    run_tracking(4 * mmtr_pkg::ONE_SAMPLE, 8 * mmtr_pkg::ONE_SAMPLE, mmtr_pkg::ONE_SAMPLE,
                 GAIN_MIN, 150);
    // largest step: a symbol every 255 to 256 samples, kept last and short
    run_tracking(STEP_TOP, STEP_TOP, STEP_TOP - mmtr_pkg::ONE_SAMPLE, 1000, 300);

    wait_idle();
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    $display("tb: %0d samples, %0d symbols, %0d register writes over %0d settings",
             n_samples, n_symbols, n_writes, n_settings);
    $display("tb: unit to full-scale steps, inverted and zero limits, gain extremes, long stall");
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", n_errors);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> mm_symbol_timing_recovery_core.f
+incdir+hw/rtl
hw/rtl/mmtr_pkg.sv
hw/rtl/mmtr_if.sv
hw/rtl/mmtr_step_calc.sv
hw/rtl/mm_symbol_timing_recovery_core.sv
tb/tb.sv
